### hdl/hss_pkg.sv
// Shared constants, types and helper functions for the Horspool substring search core.
package hss_pkg;

	localparam int MAX_PATTERN    = 16;
	localparam int POSITION_BITS  = 32;

	// Usable pattern length is bounded by both the window and the 16 pattern bytes
	localparam int PAT_BYTES      = 16;
	localparam int PAT_SEL_BITS   = 4;
	localparam int PAT_CAP        = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
	localparam int LEN_BITS       = $clog2(PAT_CAP + 1);
	localparam int IDX_BITS       = (PAT_CAP > 1) ? $clog2(PAT_CAP) : 1;
	localparam int WIN_IDX_BITS   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int POS_EXT_BITS   = POSITION_BITS + 1;

	// Fixed widths of the port fields
	localparam int BYTE_BITS      = 8;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 64;
	localparam int LEN_REG_BITS   = 5;
	localparam int POS_OUT_BITS   = 32;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [LEN_BITS-1:0]      len_t;
	typedef logic [IDX_BITS-1:0]      idx_t;
	typedef logic [BYTE_BITS-1:0]     byte_t;

	localparam pos_t POS_MAX = '1;

	// Register map
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} cfg_reg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take_byte;
		logic emit;
	} hss_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic hit;
		logic last_cmp;
	} hss_stat_t;

	// Saturating add of a length-sized value onto a position
	function automatic pos_t sat_add(input pos_t a, input len_t b);
		logic [POS_EXT_BITS-1:0] sum;
		sum = {1'b0, a} + POS_EXT_BITS'(b);
		if (sum[POSITION_BITS]) begin
			return POS_MAX;
		end
		return sum[POSITION_BITS-1:0];
	endfunction

	// Clamp the raw length register into 1..PAT_CAP
	function automatic len_t eff_len(input logic [LEN_REG_BITS-1:0] raw);
		if (raw == '0) begin
			return len_t'(1);
		end
		if (int'(raw) > PAT_CAP) begin
			return len_t'(PAT_CAP);
		end
		return len_t'(raw);
	endfunction

endpackage

### hdl/hss_in_if.sv
// Text byte input channel.
interface hss_in_if;
	import hss_pkg::*;

	logic  valid;
	logic  ready;
	byte_t text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

### hdl/hss_out_if.sv
// Compared position result channel.
interface hss_out_if;
	import hss_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [POS_OUT_BITS-1:0] compared_position;
	logic                    last_of_run;

	modport source (output valid, output compared_position, output last_of_run, input ready);
	modport sink (input valid, input compared_position, input last_of_run, output ready);
endinterface

### hdl/hss_cfg_if.sv
// Configuration register write channel.
interface hss_cfg_if;
	import hss_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] reg_index;
	logic [CFG_DATA_BITS-1:0]  reg_data;

	modport source (output valid, output reg_index, output reg_data, input ready);
	modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

### hdl/hss_ctrl.sv
// Controller state machine: byte intake and sequencing of the right-to-left compare.
module hss_ctrl
	import hss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  hss_stat_t stat,
	output hss_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_CMP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;

	// Take bytes only between alignments
	assign in_ready      = (state_q == ST_IDLE);
	assign can_load      = !out_valid_q || out_ready;
	assign cmd.take_byte = in_valid && in_ready;
	assign cmd.emit      = (state_q == ST_CMP) && can_load;
	assign out_valid     = out_valid_q;

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take_byte && stat.hit) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (cmd.emit && stat.last_cmp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/hss_dp.sv
// Datapath: pattern registers, text window, position counters, shift and compare logic.
module hss_dp
	import hss_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	hss_cfg_if.sink                  cfg,
	input  byte_t                    text_byte,
	input  hss_cmd_t                 cmd,
	output hss_stat_t                stat,
	output logic [POS_OUT_BITS-1:0]  compared_position,
	output logic                     last_of_run
);

	logic [CFG_DATA_BITS-1:0] pat_low_q;
	logic [CFG_DATA_BITS-1:0] pat_high_q;
	logic [LEN_REG_BITS-1:0]  pat_len_q;
	byte_t                    window_q [MAX_PATTERN];
	pos_t                     byte_count_q;
	pos_t                     align_end_q;
	idx_t                     idx_q;
	pos_t                     pos_q;
	logic                     last_q;

	byte_t                    pat_b [PAT_BYTES];
	len_t                     len;
	len_t                     shift;
	len_t                     pat_k;
	byte_t                    win_b;
	logic                     hit;
	logic                     last_cmp;

	assign cfg.ready = 1'b1;
	assign len       = eff_len(pat_len_q);

	// Split the pattern registers into bytes
	always_comb begin
		for (int j = 0; j < PAT_BYTES; j++) begin
			if (j < 8) begin
				pat_b[j] = pat_low_q[j*8 +: 8];
			end else begin
				pat_b[j] = pat_high_q[(j-8)*8 +: 8];
			end
		end
	end

	// Bad-character shift of the incoming byte: rightmost match below the last position
	always_comb begin
		shift = len;
		for (int k = 0; k < PAT_CAP - 1; k++) begin
			if ((len_t'(k + 1) < len) && (pat_b[k] == text_byte)) begin
				shift = len - len_t'(k + 1);
			end
		end
	end

	// Incoming byte completes the current alignment
	assign hit = (byte_count_q != POS_MAX) && ((byte_count_q + pos_t'(1)) == align_end_q);

	// Compare one window byte against its pattern byte, right to left
	assign pat_k    = len - len_t'(1) - len_t'(idx_q);
	assign win_b    = window_q[WIN_IDX_BITS'(idx_q)];
	assign last_cmp = (win_b != pat_b[PAT_SEL_BITS'(pat_k)]) ||
	                  ((len_t'(idx_q) + len_t'(1)) == len);

	assign stat.hit      = hit;
	assign stat.last_cmp = last_cmp;

	// Configuration and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q    <= '0;
			pat_high_q   <= '0;
			pat_len_q    <= LEN_REG_BITS'(1);
			byte_count_q <= '0;
			align_end_q  <= pos_t'(1);
			idx_q        <= '0;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				window_q[j] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				unique case (cfg.reg_index)
					REG_PATTERN_LOW: begin
						pat_low_q <= cfg.reg_data;
					end
					REG_PATTERN_HIGH: begin
						pat_high_q <= cfg.reg_data;
					end
					REG_PATTERN_LENGTH: begin
						pat_len_q   <= cfg.reg_data[LEN_REG_BITS-1:0];
						align_end_q <= sat_add(byte_count_q,
						                       eff_len(cfg.reg_data[LEN_REG_BITS-1:0]));
					end
					default: begin
					end
				endcase
			end
			if (cmd.take_byte) begin
				for (int j = MAX_PATTERN - 1; j > 0; j--) begin
					window_q[j] <= window_q[j-1];
				end
				window_q[0] <= text_byte;
				idx_q       <= '0;
				if (byte_count_q != POS_MAX) begin
					byte_count_q <= byte_count_q + pos_t'(1);
				end
				if (hit) begin
					align_end_q <= sat_add(align_end_q, shift);
				end
			end else if (cmd.emit) begin
				idx_q <= idx_q + idx_t'(1);
			end
		end
	end

	// Output register: load one compared position per emit
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pos_q  <= byte_count_q - pos_t'(idx_q);
			last_q <= last_cmp;
		end
	end

	assign compared_position = POS_OUT_BITS'(pos_q);
	assign last_of_run       = last_q;

endmodule

### hdl/horspool_substring_search_core.sv
// Horspool substring search core: one text byte per transfer, compared positions out.
// A byte that does not end an alignment leaves the core idle, ready for the next byte.
// A byte that ends an alignment yields n results (1..16), one per cycle unless the
// result channel stalls; the next byte is taken once the last result is issued.
// The compare sequencer checks one pattern byte per cycle while the output can load.
// arst_n clears the window and byte count, pattern to zero, length 1, alignment end 1.
module horspool_substring_search_core
	import hss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	hss_in_if.sink   text_in,
	hss_out_if.source result_out,
	hss_cfg_if.sink  cfg
);

	hss_cmd_t  cmd;
	hss_stat_t stat;

	// Sequence byte intake and result transfers
	hss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text_in.valid),
		.in_ready  (text_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold pattern, window and positions
	hss_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.text_byte         (text_in.text_byte),
		.cmd               (cmd),
		.stat              (stat),
		.compared_position (result_out.compared_position),
		.last_of_run       (result_out.last_of_run)
	);

endmodule
